>>> design/rce_pkg.sv
// Shared types, constants and helper functions for the RLE cost estimator.
// Used by rce_front, rce_fifo, rce_back and rle_cost_estimator; depends on nothing.
package rce_pkg;

    localparam int RUN_MAX    = 127;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [6:0] THRESH_RESET = 7'd2;

    // Cost terms: clocks 13 bits, enough for any single close or flush; sizes 8 bits.
    localparam logic [12:0] RPT_BASE_CLKS   = 13'd47;
    localparam logic [12:0] RPT_PER_CLKS    = 13'd13;
    localparam logic [12:0] LIT_BASE_CLKS   = 13'd46;
    localparam logic [12:0] LIT_PER_CLKS    = 13'd18;
    localparam logic [12:0] FULL_CHUNK_CLKS = 13'd2350;
    localparam logic [7:0]  FULL_CHUNK_SIZE = 8'd129;
    localparam logic [7:0]  RPT_SIZE        = 8'd2;

    // One classified item: the run it closed (if any) and, on the last byte,
    // the length of the run still open at the end of the stream.
    typedef struct packed {
        logic       close_vld;
        logic [6:0] close_len;
        logic       last;
        logic [6:0] final_len;
    } rce_evt_t;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] d);
        logic [16:0] s;
        s = {1'b0, a} + {9'd0, d};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [20:0] sat_add21(input logic [20:0] a, input logic [12:0] d);
        logic [21:0] s;
        s = {1'b0, a} + {9'd0, d};
        return s[21] ? 21'h1FFFFF : s[20:0];
    endfunction

endpackage

>>> design/rce_front.sv
// Front end: accepts bytes, tracks the open run and classifies each item.
// Depends on rce_pkg.
module rce_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              fifo_full,
    output logic              push,
    output rce_pkg::rce_evt_t evt
);
    import rce_pkg::*;

    logic [7:0] run_value_reg;
    logic [7:0] run_value_next;
    logic [6:0] run_length_reg;
    logic [6:0] run_length_next;
    logic       extend;
    logic [6:0] new_len;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        extend = (run_length_reg != 7'd0) && (data_byte == run_value_reg)
                 && (run_length_reg < 7'(RUN_MAX));
        new_len = extend ? (run_length_reg + 7'd1) : 7'd1;

        evt.close_vld = !extend && (run_length_reg != 7'd0);
        evt.close_len = run_length_reg;
        evt.last      = last_byte;
        evt.final_len = new_len;

        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        if (push)
        begin
            if (last_byte)
            begin
                run_value_next  = 8'd0;
                run_length_next = 7'd0;
            end
            else
            begin
                run_value_next  = data_byte;
                run_length_next = new_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= 8'd0;
            run_length_reg <= 7'd0;
        end
        else
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

>>> design/rce_fifo.sv
// Short queue of classified items between the front and back ends.
// Depends on rce_pkg.
module rce_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rce_pkg::rce_evt_t push_data,
    output logic              full,
    input  logic              pop,
    output rce_pkg::rce_evt_t pop_data,
    output logic              not_empty
);
    import rce_pkg::*;

    rce_evt_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + FIFO_AW'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + FIFO_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

>>> design/rce_back.sv
// Back end: applies the cost of closed runs and literal chunks to the totals
// and presents the result of each stream in an output register. Depends on rce_pkg.
module rce_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [6:0]        run_threshold,
    input  logic              evt_valid,
    input  rce_pkg::rce_evt_t evt,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       encoded_size,
    output logic [20:0]       decode_clocks
);
    import rce_pkg::*;

    typedef enum logic [1:0] {
        PH_CLOSE1,
        PH_CLOSE2,
        PH_FINAL
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [6:0]  pending_reg;
    logic [6:0]  pending_next;
    logic [15:0] size_total_reg;
    logic [15:0] size_total_next;
    logic [20:0] clock_total_reg;
    logic [20:0] clock_total_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] encoded_size_reg;
    logic [15:0] encoded_size_next;
    logic [20:0] decode_clocks_reg;
    logic [20:0] decode_clocks_next;

    logic        close_en;
    logic [6:0]  close_len;
    logic        repeat_run;
    logic [7:0]  lit_sum;
    logic [12:0] lit_clks;
    logic [12:0] run_clks;
    logic [7:0]  c_dsize;
    logic [12:0] c_dclk;
    logic [6:0]  c_pend;
    logic [7:0]  f_dsize;
    logic [12:0] f_dclk;

    assign out_valid     = out_valid_reg;
    assign encoded_size  = encoded_size_reg;
    assign decode_clocks = decode_clocks_reg;

    always_comb
    begin
        close_len  = (phase_reg == PH_CLOSE1) ? evt.close_len : evt.final_len;
        close_en   = evt_valid && (((phase_reg == PH_CLOSE1) && evt.close_vld)
                                   || (phase_reg == PH_CLOSE2));
        repeat_run = close_len > run_threshold;
        lit_sum    = {1'b0, pending_reg} + {1'b0, close_len};
        lit_clks   = LIT_BASE_CLKS + LIT_PER_CLKS * {6'd0, pending_reg};
        run_clks   = RPT_BASE_CLKS + RPT_PER_CLKS * {6'd0, close_len};

        // A repeat run first flushes whatever literals are pending.
        if (repeat_run)
        begin
            c_pend = 7'd0;
            if (pending_reg != 7'd0)
            begin
                c_dsize = {1'b0, pending_reg} + 8'd1 + RPT_SIZE;
                c_dclk  = lit_clks + run_clks;
            end
            else
            begin
                c_dsize = RPT_SIZE;
                c_dclk  = run_clks;
            end
        end
        else if (lit_sum[7])
        begin
            c_pend  = lit_sum[6:0];
            c_dsize = FULL_CHUNK_SIZE;
            c_dclk  = FULL_CHUNK_CLKS;
        end
        else
        begin
            c_pend  = lit_sum[6:0];
            c_dsize = 8'd0;
            c_dclk  = 13'd0;
        end

        // End of stream: flush the remaining literals and add the terminator.
        if (pending_reg != 7'd0)
        begin
            f_dsize = {1'b0, pending_reg} + 8'd2;
            f_dclk  = lit_clks;
        end
        else
        begin
            f_dsize = 8'd1;
            f_dclk  = 13'd0;
        end

        phase_next         = phase_reg;
        pending_next       = pending_reg;
        size_total_next    = size_total_reg;
        clock_total_next   = clock_total_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        encoded_size_next  = encoded_size_reg;
        decode_clocks_next = decode_clocks_reg;
        pop                = 1'b0;

        if (close_en)
        begin
            pending_next     = c_pend;
            size_total_next  = sat_add16(size_total_reg, c_dsize);
            clock_total_next = sat_add21(clock_total_reg, c_dclk);
        end

        case (phase_reg)
            PH_CLOSE1:
            begin
                if (evt_valid)
                begin
                    if (evt.last)
                    begin
                        phase_next = PH_CLOSE2;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            PH_CLOSE2:
            begin
                phase_next = PH_FINAL;
            end
            PH_FINAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    encoded_size_next  = sat_add16(size_total_reg, f_dsize);
                    decode_clocks_next = sat_add21(clock_total_reg, f_dclk);
                    out_valid_next     = 1'b1;
                    pop                = 1'b1;
                    pending_next       = 7'd0;
                    size_total_next    = 16'd0;
                    clock_total_next   = 21'd0;
                    phase_next         = PH_CLOSE1;
                end
            end
            default:
            begin
                phase_next = PH_CLOSE1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_CLOSE1;
            pending_reg       <= 7'd0;
            size_total_reg    <= 16'd0;
            clock_total_reg   <= 21'd0;
            out_valid_reg     <= 1'b0;
            encoded_size_reg  <= 16'd0;
            decode_clocks_reg <= 21'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            pending_reg       <= pending_next;
            size_total_reg    <= size_total_next;
            clock_total_reg   <= clock_total_next;
            out_valid_reg     <= out_valid_next;
            encoded_size_reg  <= encoded_size_next;
            decode_clocks_reg <= decode_clocks_next;
        end
    end

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_CLOSE1) |-> evt_valid)
        else $error("queue head lost during end-of-stream sequence");

    a_close2_last: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CLOSE2) |-> evt.last)
        else $error("second close step on an item that is not last");

    a_stream_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && evt.last) |=> (size_total_reg == 16'd0) && (pending_reg == 7'd0)
                              && (clock_total_reg == 21'd0) && out_valid_reg)
        else $error("totals not cleared after stream end");

endmodule

>>> design/rle_cost_estimator.sv
// Top level of the RLE cost estimator: threshold register, front end, queue, back end.
// Depends on rce_pkg, rce_front, rce_fifo and rce_back.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    data_byte, last_byte
//   result    out        out_valid / out_ready  encoded_size, decode_clocks
//   config    in         cfg_wr_en              cfg_wr_data (run_threshold)
//
// A byte without the last flag is taken every cycle while the queue is not full.
// A last byte takes the back end through two run closes and the final flush.
// The four-entry queue absorbs those extra steps when last bytes are occasional;
// a long sequence of one-byte streams fills it and then holds the input back.
// Reset clears the open run, pending literals and totals; the threshold resets to 2.
// A stalled result holds the back end only when it reaches its final step.
module rle_cost_estimator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] encoded_size,
    output logic [20:0] decode_clocks,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);
    import rce_pkg::*;

    logic [6:0] threshold_reg;
    logic [6:0] threshold_next;
    logic       fifo_full;
    logic       push;
    rce_evt_t   push_evt;
    logic       pop;
    rce_evt_t   head_evt;
    logic       head_valid;

    assign threshold_next = cfg_wr_en ? cfg_wr_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    rce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .fifo_full (fifo_full),
        .push      (push),
        .evt       (push_evt)
    );

    rce_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_evt),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (head_evt),
        .not_empty (head_valid)
    );

    rce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .run_threshold (threshold_reg),
        .evt_valid     (head_valid),
        .evt           (head_evt),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .encoded_size  (encoded_size),
        .decode_clocks (decode_clocks)
    );

endmodule
